### hdl/csma_ca_backoff_sequencer_defines.svh
// ----------------------------------------------------------------------------
// csma_ca_backoff_sequencer_defines
// assertion macros shared by the checker; they expect clk and rst_n in scope
// ----------------------------------------------------------------------------
`ifndef CSMA_CA_BACKOFF_SEQUENCER_DEFINES_SVH
`define CSMA_CA_BACKOFF_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define CSMA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csma sequencer: same-cycle check failed");

// next-cycle implication
`define CSMA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csma sequencer: next-cycle check failed");

`endif

### hdl/csma_pkg.sv
// ----------------------------------------------------------------------------
// csma_pkg
// widths, phase codes, register indexes and the draw unit request/response
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csma_pkg;

    localparam int RANDOM_BITS = 15;
    localparam int DIFS_W      = 4;
    localparam int WINDOW_W    = 10;
    localparam int RETRY_W     = 8;
    localparam int PEND_W      = 8;
    localparam int PHASE_W     = 4;
    localparam int FRAMES_W    = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = WINDOW_W;
    localparam int PROD_W      = WINDOW_W + RETRY_W + 1;
    localparam int STEP_W      = $clog2(RANDOM_BITS);

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DIFS_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_MIN  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_CAP  = 2'd2;

    localparam logic [DIFS_W-1:0]   DIFS_RESET = 4'd3;
    localparam logic [WINDOW_W-1:0] WMIN_RESET = 10'd15;
    localparam logic [WINDOW_W-1:0] WCAP_RESET = 10'd1023;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_DIFS    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_BACKOFF = 4'd2;
    localparam logic [PHASE_W-1:0] PH_RTS     = 4'd3;
    localparam logic [PHASE_W-1:0] PH_SIFS1   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_CTS     = 4'd5;
    localparam logic [PHASE_W-1:0] PH_SIFS2   = 4'd6;
    localparam logic [PHASE_W-1:0] PH_DATA    = 4'd7;
    localparam logic [PHASE_W-1:0] PH_SIFS3   = 4'd8;
    localparam logic [PHASE_W-1:0] PH_ACK     = 4'd9;

    typedef struct packed {
        logic                   start;
        logic [RETRY_W-1:0]     retry;
        logic [RANDOM_BITS-1:0] rnd;
        logic [WINDOW_W-1:0]    wmin;
        logic [WINDOW_W-1:0]    wcap;
    } draw_req_t;

    typedef struct packed {
        logic                done;
        logic [WINDOW_W-1:0] value;
    } draw_rsp_t;

endpackage

`default_nettype wire

### hdl/csma_in_if.sv
// ----------------------------------------------------------------------------
// csma_in_if
// tick item channel: channel state, random draw, new frames, skip flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface csma_in_if;
    import csma_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   channel_busy;
    logic [RANDOM_BITS-1:0] random_value;
    logic [FRAMES_W-1:0]    new_frames;
    logic                   inactive;

    modport source (
        output valid, channel_busy, random_value, new_frames, inactive,
        input  ready
    );

    modport sink (
        input  valid, channel_busy, random_value, new_frames, inactive,
        output ready
    );
endinterface

`default_nettype wire

### hdl/csma_out_if.sv
// ----------------------------------------------------------------------------
// csma_out_if
// result item channel: phase, channel occupation, sent flag, counters
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface csma_out_if;
    import csma_pkg::*;

    logic               valid;
    logic               ready;
    logic [PHASE_W-1:0] phase;
    logic               occupy_channel;
    logic               frame_sent;
    logic [PEND_W-1:0]  pending_count;
    logic [RETRY_W-1:0] retries;

    modport source (
        output valid, phase, occupy_channel, frame_sent, pending_count, retries,
        input  ready
    );

    modport sink (
        input  valid, phase, occupy_channel, frame_sent, pending_count, retries,
        output ready
    );
endinterface

`default_nettype wire

### hdl/csma_ca_backoff_sequencer.sv
// ----------------------------------------------------------------------------
// csma_ca_backoff_sequencer
// slot-tick CSMA/CA transmit sequencer with linear window-growth backoff
// ----------------------------------------------------------------------------
// One input item is one slot tick and gives one result item. A tick that needs
// no backoff draw passes through the commit state into the result register, and
// in_ch.ready returns when that result is written, so a new tick is taken only
// once the last one is through. A tick that leaves DIFS draws a backoff. With a
// retry count of zero or a window that cannot grow past the minimum, the draw
// ends at the cap compare. Otherwise the draw unit runs the window multiply, the
// cap compare, one remainder bit per cycle over the random value and the final
// add, and then the value is handed back and committed. in_ch.ready is high
// only between ticks; a finished result sits in the output register until
// taken, and the next tick's update waits for that register to be free.
`timescale 1ns / 1ps
`default_nettype none

module csma_ca_backoff_sequencer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [csma_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [csma_pkg::CFG_DATA_W-1:0]  cfg_data,
    csma_in_if.sink                              in_ch,
    csma_out_if.source                           out_ch
);
    import csma_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE   = 3'b001,
        C_DRAW   = 3'b010,
        C_COMMIT = 3'b100
    } ctrl_state_t;

    ctrl_state_t ctrl_reg, ctrl_next;

    // configuration
    logic [DIFS_W-1:0]   difs_reg;
    logic [WINDOW_W-1:0] wmin_reg, wcap_reg;

    // sequencer state
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [DIFS_W-1:0]   ifs_reg, ifs_next;
    logic [WINDOW_W-1:0] backoff_reg, backoff_next;
    logic [RETRY_W-1:0]  retry_reg, retry_next;
    logic [PEND_W-1:0]   pend_reg, pend_next;

    // latched item
    logic                busy_reg;
    logic [FRAMES_W-1:0] frames_reg;
    logic                skip_reg;

    // result register
    logic                out_valid_reg;
    logic [PHASE_W-1:0]  out_phase_reg;
    logic                out_occupy_reg, out_sent_reg;
    logic [PEND_W-1:0]   out_pend_reg;
    logic [RETRY_W-1:0]  out_retry_reg;

    logic                occupy, sent;
    logic                accept, need_draw, out_free, commit;
    logic [PEND_W:0]     pend_sum;
    logic [PEND_W-1:0]   pend_add;
    draw_req_t           draw_req;
    draw_rsp_t           draw_rsp;

    assign accept    = in_ch.valid && in_ch.ready;
    assign need_draw = !in_ch.inactive && phase_reg == PH_DIFS &&
                       (in_ch.channel_busy || ifs_reg == '0);
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign commit    = ctrl_reg == C_COMMIT && out_free;

    assign draw_req.start = accept && need_draw;
    assign draw_req.retry = retry_reg;
    assign draw_req.rnd   = in_ch.random_value;
    assign draw_req.wmin  = wmin_reg;
    assign draw_req.wcap  = wcap_reg;

    csma_draw u_draw (
        .clk (clk),
        .rst_n (rst_n),
        .req (draw_req),
        .rsp (draw_rsp)
    );

    always_comb
    begin
        ctrl_next = ctrl_reg;
        case (ctrl_reg)
            C_IDLE:   if (accept) ctrl_next = need_draw ? C_DRAW : C_COMMIT;
            C_DRAW:   if (draw_rsp.done) ctrl_next = C_COMMIT;
            C_COMMIT: if (out_free) ctrl_next = C_IDLE;
            default:  ctrl_next = C_IDLE;
        endcase
    end

    // saturating add of the newly queued frames
    assign pend_sum = {1'b0, pend_reg} + PEND_W'(frames_reg);
    assign pend_add = pend_sum[PEND_W] ? {PEND_W{1'b1}} : pend_sum[PEND_W-1:0];

    always_comb
    begin
        phase_next   = phase_reg;
        ifs_next     = ifs_reg;
        backoff_next = backoff_reg;
        retry_next   = retry_reg;
        pend_next    = pend_reg;
        occupy       = 1'b0;
        sent         = 1'b0;
        if (!skip_reg)
        begin
            pend_next = pend_add;
            case (phase_reg)
                PH_DIFS:
                begin
                    if (busy_reg)
                    begin
                        backoff_next = draw_rsp.value;
                        if (retry_reg != {RETRY_W{1'b1}})
                            retry_next = retry_reg + 1'b1;
                        phase_next = PH_BACKOFF;
                    end
                    else if (ifs_reg == '0)
                    begin
                        backoff_next = draw_rsp.value;
                        phase_next   = PH_BACKOFF;
                    end
                    else
                    begin
                        ifs_next = ifs_reg - 1'b1;
                    end
                end
                PH_BACKOFF:
                begin
                    if (busy_reg)
                        phase_next = PH_IDLE;
                    else if (backoff_reg == '0)
                        phase_next = PH_RTS;
                    else
                        backoff_next = backoff_reg - 1'b1;
                end
                PH_RTS, PH_CTS, PH_DATA:
                begin
                    occupy     = 1'b1;
                    phase_next = phase_reg + 1'b1;
                end
                PH_SIFS1, PH_SIFS2, PH_SIFS3:
                begin
                    phase_next = phase_reg + 1'b1;
                end
                PH_ACK:
                begin
                    occupy = 1'b1;
                    if (pend_add != '0)
                    begin
                        pend_next = pend_add - 1'b1;
                        sent      = 1'b1;
                    end
                    retry_next = '0;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    // idle and the unused codes
                    if (pend_add != '0)
                    begin
                        phase_next = PH_DIFS;
                        ifs_next   = difs_reg;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg      <= C_IDLE;
            difs_reg      <= DIFS_RESET;
            wmin_reg      <= WMIN_RESET;
            wcap_reg      <= WCAP_RESET;
            phase_reg     <= PH_IDLE;
            ifs_reg       <= '0;
            backoff_reg   <= '0;
            retry_reg     <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DIFS_LENGTH: difs_reg <= cfg_data[DIFS_W-1:0];
                    REG_WINDOW_MIN:  wmin_reg <= cfg_data[WINDOW_W-1:0];
                    REG_WINDOW_CAP:  wcap_reg <= cfg_data[WINDOW_W-1:0];
                    default:         difs_reg <= difs_reg;
                endcase
            end
            if (commit)
            begin
                phase_reg   <= phase_next;
                ifs_reg     <= ifs_next;
                backoff_reg <= backoff_next;
                retry_reg   <= retry_next;
                pend_reg    <= pend_next;
            end
            if (commit)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            busy_reg   <= in_ch.channel_busy;
            frames_reg <= in_ch.new_frames;
            skip_reg   <= in_ch.inactive;
        end
        if (commit)
        begin
            out_phase_reg  <= phase_next;
            out_occupy_reg <= occupy;
            out_sent_reg   <= sent;
            out_pend_reg   <= pend_next;
            out_retry_reg  <= retry_next;
        end
    end

    assign in_ch.ready           = ctrl_reg == C_IDLE;
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.phase          = out_phase_reg;
    assign out_ch.occupy_channel = out_occupy_reg;
    assign out_ch.frame_sent     = out_sent_reg;
    assign out_ch.pending_count  = out_pend_reg;
    assign out_ch.retries        = out_retry_reg;

endmodule

`default_nettype wire

### hdl/csma_draw.sv
// ----------------------------------------------------------------------------
// csma_draw
// backoff draw: window growth by one multiply, then a bit-serial remainder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csma_draw (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire csma_pkg::draw_req_t  req,
    output      csma_pkg::draw_rsp_t  rsp
);
    import csma_pkg::*;

    typedef enum logic [4:0] {
        D_IDLE = 5'b00001,
        D_MUL  = 5'b00010,
        D_CAP  = 5'b00100,
        D_DIV  = 5'b01000,
        D_FIX  = 5'b10000
    } draw_state_t;

    draw_state_t            st_reg, st_next;
    logic [WINDOW_W-1:0]    wmin_reg, wcap_reg;
    logic [RETRY_W-1:0]     retry_reg;
    logic [RANDOM_BITS-1:0] rnd_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [WINDOW_W-1:0]    div_reg;
    logic [WINDOW_W-1:0]    rem_reg;
    logic [STEP_W-1:0]      cnt_reg;
    logic [WINDOW_W-1:0]    res_reg;
    logic                   done_reg;

    logic [WINDOW_W-1:0]    cap;
    logic [WINDOW_W:0]      trial;
    logic                   fits;

    // grown window, limited by the cap register
    assign cap = (prod_reg > PROD_W'(wcap_reg)) ? wcap_reg : prod_reg[WINDOW_W-1:0];

    // compare-subtract: one quotient bit per cycle
    assign trial = {rem_reg, rnd_reg[RANDOM_BITS-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            D_IDLE:  if (req.start) st_next = D_MUL;
            D_MUL:   st_next = D_CAP;
            D_CAP:
            begin
                if (retry_reg == '0 || cap <= wmin_reg)
                    st_next = D_IDLE;
                else
                    st_next = D_DIV;
            end
            D_DIV:   if (cnt_reg == STEP_W'(RANDOM_BITS - 1)) st_next = D_FIX;
            D_FIX:   st_next = D_IDLE;
            default: st_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= D_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= (st_reg == D_FIX) ||
                        (st_reg == D_CAP && (retry_reg == '0 || cap <= wmin_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    wmin_reg  <= req.wmin;
                    wcap_reg  <= req.wcap;
                    retry_reg <= req.retry;
                    rnd_reg   <= req.rnd;
                end
            end
            D_MUL:
            begin
                prod_reg <= (PROD_W'(wmin_reg) * PROD_W'(retry_reg)) << 1;
            end
            D_CAP:
            begin
                res_reg <= wmin_reg;
                div_reg <= cap - wmin_reg;
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            D_DIV:
            begin
                rem_reg <= fits ? WINDOW_W'(trial - {1'b0, div_reg}) : trial[WINDOW_W-1:0];
                rnd_reg <= {rnd_reg[RANDOM_BITS-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
            end
            D_FIX:
            begin
                res_reg <= rem_reg + wmin_reg;
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    assign rsp.done  = done_reg;
    assign rsp.value = res_reg;

endmodule

`default_nettype wire

### hdl/csma_chk.sv
// ----------------------------------------------------------------------------
// csma_chk
// port-level checks on the sequencer, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "csma_ca_backoff_sequencer_defines.svh"

module csma_chk (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [csma_pkg::PHASE_W-1:0] phase,
    input wire logic                         occupy_channel,
    input wire logic                         frame_sent,
    input wire logic [csma_pkg::RETRY_W-1:0] retries
);
    import csma_pkg::*;

    logic                       idle_clear;
    logic                       gap_or_idle;
    logic [PHASE_W+RETRY_W:0]   shown;

    assign idle_clear  = occupy_channel && phase == PH_IDLE && retries == '0;
    assign gap_or_idle = phase == PH_SIFS1 || phase == PH_SIFS2 ||
                         phase == PH_SIFS3 || phase == PH_IDLE;
    assign shown       = {phase, retries, frame_sent};

    // one tick at a time: the block is busy right after taking an item
    `CSMA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // a sent frame ends the handshake: back to idle with retries cleared
    `CSMA_ASSERT_NOW(a_sent_ends_exchange, out_valid && frame_sent, idle_clear)

    // transmitting steps always land in the following gap or in idle
    `CSMA_ASSERT_NOW(a_occupy_phase, out_valid && occupy_channel, gap_or_idle)

    `CSMA_ASSERT_NOW(a_phase_range, out_valid, phase <= PH_ACK)

    `CSMA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(shown))

endmodule

bind csma_ca_backoff_sequencer csma_chk u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .phase          (out_ch.phase),
    .occupy_channel (out_ch.occupy_channel),
    .frame_sent     (out_ch.frame_sent),
    .retries        (out_ch.retries)
);

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// slot-tick checks for the CSMA/CA backoff sequencer: ticks go in from a
// queue, results are compared field by field against a local tick-by-tick
// model of the phase machine, over several register settings and stall mixes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import csma_pkg::*;

    localparam int          IFS_W       = 5;
    localparam int          BACKOFF_W   = 11;
    localparam int          HOLD_CYCLES = 300;
    localparam int          SETTLE      = 25;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic                   busy;
        logic [RANDOM_BITS-1:0] rnd;
        logic [FRAMES_W-1:0]    frames;
        logic                   skip;
    } tick_t;

    typedef struct packed {
        logic [PHASE_W-1:0] ph;
        logic               occupy;
        logic               sent;
        logic [PEND_W-1:0]  pending;
        logic [RETRY_W-1:0] retries;
    } status_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_DIFS_LENGTH;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic  tick_valid   = 1'b0;
    tick_t tick_out     = '0;
    logic  status_ready = 1'b0;

    csma_in_if  tick_if ();
    csma_out_if status_if ();

    assign tick_if.valid        = tick_valid;
    assign tick_if.channel_busy = tick_out.busy;
    assign tick_if.random_value = tick_out.rnd;
    assign tick_if.new_frames   = tick_out.frames;
    assign tick_if.inactive     = tick_out.skip;
    assign status_if.ready      = status_ready;

    csma_ca_backoff_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (tick_if),
        .out_ch    (status_if)
    );

    // local copy of the registers and the sequencer state
    logic [DIFS_W-1:0]    cfg_difs = DIFS_RESET;
    logic [WINDOW_W-1:0]  cfg_wmin = WMIN_RESET;
    logic [WINDOW_W-1:0]  cfg_wcap = WCAP_RESET;
    logic [PHASE_W-1:0]   seq_phase   = PH_IDLE;
    logic [IFS_W-1:0]     seq_ifs     = '0;
    logic [BACKOFF_W-1:0] seq_backoff = '0;
    logic [RETRY_W-1:0]   seq_retries = '0;
    logic [PEND_W-1:0]    seq_pending = '0;

    tick_t   tick_queue[$];
    status_t status_due[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int ticks_sent = 0;
    int results_seen = 0;
    int frames_sent_seen = 0;
    int peak_retries = 0;
    int peak_pending = 0;
    int settings_run = 0;

    logic hold_go   = 1'b0;
    logic hold_used = 1'b0;
    int   hold_left = 0;
    int unsigned cycle_count = 0;

    function automatic logic [BACKOFF_W-1:0] backoff_draw(input logic [RETRY_W-1:0] retry,
                                                          input logic [RANDOM_BITS-1:0] rnd);
        int unsigned wmin;
        int unsigned cap;
        int unsigned draw;
        wmin = cfg_wmin;
        if (retry == 0)
            draw = wmin;
        else
        begin
            cap = wmin * 2 * retry;
            if (cap > cfg_wcap)
                cap = cfg_wcap;
            // a window that cannot grow past the minimum gives the minimum
            if (cap <= wmin)
                draw = wmin;
            else
                draw = (rnd % (cap - wmin)) + wmin;
        end
        return draw[BACKOFF_W-1:0];
    endfunction

    function automatic status_t advance_sequencer(input tick_t t);
        status_t     s;
        int unsigned sum;
        s = '0;
        if (!t.skip)
        begin
            sum = seq_pending + t.frames;
            seq_pending = (sum > 255) ? 8'd255 : sum[PEND_W-1:0];
            case (seq_phase)
                PH_DIFS:
                begin
                    if (t.busy)
                    begin
                        seq_backoff = backoff_draw(seq_retries, t.rnd);
                        if (seq_retries != 8'd255)
                            seq_retries = seq_retries + 1'b1;
                        seq_phase = PH_BACKOFF;
                    end
                    else if (seq_ifs == 0)
                    begin
                        seq_backoff = backoff_draw(seq_retries, t.rnd);
                        seq_phase = PH_BACKOFF;
                    end
                    else
                        seq_ifs = seq_ifs - 1'b1;
                end
                PH_BACKOFF:
                begin
                    if (t.busy)
                        seq_phase = PH_IDLE;
                    else if (seq_backoff == 0)
                        seq_phase = PH_RTS;
                    else
                        seq_backoff = seq_backoff - 1'b1;
                end
                PH_RTS, PH_CTS, PH_DATA:
                begin
                    s.occupy = 1'b1;
                    seq_phase = seq_phase + 1'b1;
                end
                PH_SIFS1, PH_SIFS2, PH_SIFS3:
                    seq_phase = seq_phase + 1'b1;
                PH_ACK:
                begin
                    s.occupy = 1'b1;
                    if (seq_pending != 0)
                    begin
                        seq_pending = seq_pending - 1'b1;
                        s.sent = 1'b1;
                    end
                    seq_retries = '0;
                    seq_phase = PH_IDLE;
                end
                default:
                begin
                    if (seq_pending != 0)
                    begin
                        seq_phase = PH_DIFS;
                        seq_ifs = {1'b0, cfg_difs};
                    end
                    else
                        seq_phase = PH_IDLE;
                end
            endcase
        end
        s.ph      = seq_phase;
        s.pending = seq_pending;
        s.retries = seq_retries;
        return s;
    endfunction

    task automatic check_status(input status_t got);
        status_t want;
        results_seen++;
        if (got.sent)
            frames_sent_seen++;
        if (got.retries > peak_retries)
            peak_retries = got.retries;
        if (got.pending > peak_pending)
            peak_pending = got.pending;
        if (status_due.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("result %0d arrived with no tick waiting: phase %0d pend %0d retry %0d",
                         results_seen, got.ph, got.pending, got.retries);
        end
        else
        begin
            want = status_due.pop_front();
            if (got.ph !== want.ph || got.occupy !== want.occupy || got.sent !== want.sent ||
                got.pending !== want.pending || got.retries !== want.retries)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display({"result %0d: expected phase %0d occ %0b sent %0b pend %0d ",
                              "retry %0d, got phase %0d occ %0b sent %0b pend %0d retry %0d"},
                             results_seen, want.ph, want.occupy, want.sent, want.pending,
                             want.retries, got.ph, got.occupy, got.sent, got.pending,
                             got.retries);
            end
        end
    endtask

    task automatic push_tick(input logic busy, input int unsigned rnd, input int unsigned frames,
                             input logic skip);
        tick_t t;
        t.busy   = busy;
        t.rnd    = rnd[RANDOM_BITS-1:0];
        t.frames = frames[FRAMES_W-1:0];
        t.skip   = skip;
        tick_queue = {tick_queue, t};
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_DIFS_LENGTH: cfg_difs = val[DIFS_W-1:0];
            REG_WINDOW_MIN:  cfg_wmin = val[WINDOW_W-1:0];
            REG_WINDOW_CAP:  cfg_wcap = val[WINDOW_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_windows(input int unsigned difs, input int unsigned wmin,
                               input int unsigned wcap);
        write_reg(REG_DIFS_LENGTH, difs);
        write_reg(REG_WINDOW_MIN, wmin);
        write_reg(REG_WINDOW_CAP, wcap);
        settings_run++;
    endtask

    // block is idle once nothing is queued, offered or owed
    task automatic drain();
        @(negedge clk);
        while (tick_queue.size() != 0 || tick_valid || status_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_phase(input int unsigned difs, input int unsigned wmin,
                             input int unsigned wcap, input int busy_pct, input int send_idle,
                             input int recv_idle, input int count);
        int r;
        int frames;
        set_windows(difs, wmin, wcap);
        @(negedge clk);
        send_idle_pct = send_idle;
        recv_idle_pct = recv_idle;
        repeat (count)
        begin
            r = $urandom_range(99);
            frames = (r < 92) ? 0 : (r < 97) ? 1 : 2;
            push_tick($urandom_range(99) < busy_pct, $urandom_range(32767), frames,
                      $urandom_range(99) < 6);
        end
        drain();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // tick driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid <= 1'b0;
        end
        else
        begin
            if (tick_valid && tick_if.ready)
            begin
                status_due = {status_due, advance_sequencer(tick_out)};
                ticks_sent++;
            end
            if (!tick_valid || tick_if.ready)
            begin
                if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    tick_valid <= 1'b1;
                    tick_out   <= tick_queue.pop_front();
                end
                else
                    tick_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_ready <= 1'b0;
        end
        else
        begin
            if (status_if.valid && status_ready)
                check_status({status_if.phase, status_if.occupy_channel, status_if.frame_sent,
                              status_if.pending_count, status_if.retries});
            status_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one long receiver hold-off so the sequencer backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_go && !hold_used)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     status_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // short windows so one full exchange fits in a few ticks
        send_idle_pct = 38;
        recv_idle_pct = 77;
        set_windows(0, 1, 3);
        @(negedge clk);
        push_tick(1'b0, 32767, 1, 1'b0);
        push_tick(1'b0, 0, 0, 1'b0);
        push_tick(1'b0, 0, 0, 1'b0);
        push_tick(1'b0, 0, 0, 1'b0);
        push_tick(1'b1, 0, 0, 1'b0);   // busy while sending rts has no effect
        push_tick(1'b0, 0, 2, 1'b1);   // skipped tick does not queue its frames
        repeat (6) push_tick(1'b0, 0, 0, 1'b0);
        push_tick(1'b0, 0, 2, 1'b0);
        push_tick(1'b1, 32767, 0, 1'b0);
        push_tick(1'b1, 0, 1, 1'b0);
        push_tick(1'b0, 0, 0, 1'b0);
        push_tick(1'b1, 0, 0, 1'b0);   // retry one, draw still at the minimum
        push_tick(1'b1, 0, 0, 1'b0);
        push_tick(1'b0, 0, 0, 1'b0);
        push_tick(1'b0, 32767, 0, 1'b0);   // window capped
        repeat (7) push_tick(1'b0, $urandom_range(32767), 0, 1'b0);
        drain();

        run_phase(3, 15, 1023, 5, 38, 77, 350);
        run_phase(15, 1023, 1023, 10, 38, 77, 100);
        // near-constant busy channel
        run_phase(0, 1, 1023, 98, 77, 38, 800);
        run_phase(1, 0, 1, 30, 77, 38, 150);
        @(negedge clk);
        hold_go = 1'b1;
        run_phase(2, 4, 40, 8, 0, 0, 350);

        $display("covered %0d ticks over %0d register settings, %0d frames sent",
                 ticks_sent, settings_run, frames_sent_seen);
        $display("retry count peaked at %0d, queue at %0d, %0d result mismatches",
                 peak_retries, peak_pending, mismatch_count);
        if (mismatch_count == 0 && status_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
